FILE: hdl/xpoc_pkg.sv
// Package for the XML path occurrence counter.
// Holds sizes, codes, port word types and helper functions.
// Used by every module of the block except xpoc_ram; depends on nothing.
package xpoc_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int HIST_BINS  = 16;
  localparam int TAG_BITS   = 8;

  localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int BIN_W   = $clog2(HIST_BINS);
  localparam int LEN_W   = 4;
  localparam int DEPTH_W = 16;
  localparam int CNT_W   = 32;
  localparam int CHILD_W = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
  localparam logic [CHILD_W-1:0] CHILD_MAX = {CHILD_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_PATH_LENGTH = 2'd0,
    CFG_PATH_TAGS   = 2'd1,
    CFG_GROUP_MODE  = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] tag_id;
    logic [2:0] read_level;
    logic [3:0] read_bin;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]   occurrence_count;
    logic [CNT_W-1:0]   histogram_count;
    logic [DEPTH_W-1:0] current_depth;
    logic               depth_error;
  } out_t;

  typedef struct packed {
    logic               inc0;
    logic               incn;
    logic               rd_en;
    logic               rd_hi;
    logic [BIN_W-1:0]   bin0;
    logic [LVL_W-1:0]   lvln;
    logic [BIN_W-1:0]   binn;
  } hist_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]   occ;
    logic [DEPTH_W-1:0] depth;
    logic               err;
  } path_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    sat_inc32 = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [BIN_W-1:0] child_bin(input logic [CHILD_W-1:0] c);
    child_bin = (c >= CHILD_W'(HIST_BINS - 1)) ? BIN_W'(HIST_BINS - 1) : c[BIN_W-1:0];
  endfunction

  function automatic logic [BIN_W-1:0] read_bin_addr(input logic [3:0] rb);
    logic [8:0] w;
    w = {5'b0, rb};
    read_bin_addr = w[BIN_W-1:0];
  endfunction

  function automatic logic read_bin_ok(input logic [3:0] rb);
    read_bin_ok = ({5'b0, rb} < 9'(HIST_BINS));
  endfunction

endpackage

FILE: hdl/xpoc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and updated only on a read enable.
// Depends on nothing.
module xpoc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/xpoc_path.sv
// Path tracking: configuration registers, nesting depth, per-level flags,
// match and child counters. Issues histogram requests per event.
// Depends on xpoc_pkg.
module xpoc_path
  import xpoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        accept_i,
  input  in_t         in_i,
  output path_rsp_t   rsp_o,
  output hist_req_t   req_o
);

  logic [LEN_W-1:0]   path_length_q;
  logic [63:0]        path_tags_q;
  logic               group_mode_q;

  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [MAX_LEVELS-1:0] on_path_q, on_path_d;
  logic [CNT_W-1:0]   match_q [MAX_LEVELS];
  logic [CNT_W-1:0]   match_d [MAX_LEVELS];
  logic [CHILD_W-1:0] child_q [MAX_LEVELS];
  logic [CHILD_W-1:0] child_d [MAX_LEVELS];

  logic [LEN_W-1:0]   eff_len;
  logic [DEPTH_W-1:0] d;
  logic [LVL_W-1:0]   d_lvl;
  logic [LVL_W-1:0]   d_up;
  logic [LVL_W-1:0]   rd_lvl;
  logic [LVL_W-1:0]   m_idx;
  logic               in_path;
  logic               next_in;
  logic               lvl_ok;
  logic               tag_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_length_q <= LEN_W'(1);
      path_tags_q   <= '0;
      group_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATH_LENGTH: path_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_PATH_TAGS:   path_tags_q   <= cfg_data_i;
        CFG_GROUP_MODE:  group_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = (path_length_q > LEN_W'(MAX_LEVELS)) ? LEN_W'(MAX_LEVELS) : path_length_q;
    d       = (in_i.func == FUNC_END) ? depth_q - 1'b1 : depth_q;
    d_lvl   = d[LVL_W-1:0];
    d_up    = d_lvl + LVL_W'(1);
    in_path = d < DEPTH_W'(eff_len);
    next_in = (LEN_W'(d_lvl) + LEN_W'(1)) < eff_len;
    rd_lvl  = in_i.read_level[LVL_W-1:0];
    lvl_ok  = LEN_W'(in_i.read_level) < LEN_W'(MAX_LEVELS);
    m_idx   = (in_i.func == FUNC_READ) ? rd_lvl : d_lvl;
    tag_hit = path_tags_q[8*d_lvl +: TAG_BITS] == in_i.tag_id[TAG_BITS-1:0];
  end

  always_comb begin
    depth_d   = depth_q;
    on_path_d = on_path_q;
    match_d   = match_q;
    child_d   = child_q;
    req_o     = '0;
    rsp_o     = '0;
    case (in_i.func)
      FUNC_START: begin
        if (depth_q == DEPTH_MAX) begin
          rsp_o.err = 1'b1;
        end else begin
          depth_d = depth_q + 1'b1;
          if (in_path) begin
            if (d != '0 && !on_path_q[d_lvl - LVL_W'(1)]) begin
              on_path_d[d_lvl] = 1'b0;
            end else if (tag_hit) begin
              on_path_d[d_lvl] = 1'b1;
              match_d[d_lvl]   = sat_inc32(match_q[m_idx]);
              if (group_mode_q) begin
                if (next_in) begin
                  child_d[d_up] = '0;
                end
                if (child_q[d_lvl] != CHILD_MAX) begin
                  child_d[d_lvl] = child_q[d_lvl] + 1'b1;
                end
              end
            end else begin
              on_path_d[d_lvl] = 1'b0;
            end
          end
        end
      end
      FUNC_END: begin
        if (depth_q == '0) begin
          rsp_o.err = 1'b1;
        end else begin
          depth_d = depth_q - 1'b1;
          if (group_mode_q && in_path && on_path_q[d_lvl]) begin
            if (next_in) begin
              req_o.incn    = 1'b1;
              req_o.lvln    = d_up;
              req_o.binn    = child_bin(child_q[d_up]);
              child_d[d_up] = '0;
            end
            if (d == '0) begin
              req_o.inc0 = 1'b1;
              req_o.bin0 = child_bin(child_q[0]);
              child_d[0] = '0;
            end
          end
        end
      end
      FUNC_READ: begin
        if (lvl_ok) begin
          rsp_o.occ = match_q[m_idx];
          if (read_bin_ok(in_i.read_bin)) begin
            req_o.rd_en = 1'b1;
            req_o.rd_hi = (rd_lvl != '0);
            req_o.bin0  = read_bin_addr(in_i.read_bin);
            req_o.lvln  = rd_lvl;
            req_o.binn  = read_bin_addr(in_i.read_bin);
          end
        end
      end
      default: ;
    endcase
    rsp_o.depth = depth_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      on_path_q <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        match_q[i] <= '0;
        child_q[i] <= '0;
      end
    end else if (accept_i) begin
      depth_q   <= depth_d;
      on_path_q <= on_path_d;
      match_q   <= match_d;
      child_q   <= child_d;
    end
  end

endmodule

FILE: hdl/xpoc_hist.sv
// Child-count histogram: level 0 and the deeper levels in two RAMs,
// read at accept, incremented and written back when the event advances.
// Depends on xpoc_pkg and xpoc_ram.
module xpoc_hist
  import xpoc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  hist_req_t        req_i,
  input  logic             advance_i,
  output logic [CNT_W-1:0] rd_data_o
);

  localparam int AN_W   = LVL_W + BIN_W;
  localparam int DEPTH0 = 2 ** BIN_W;
  localparam int DEPTHN = 2 ** AN_W;

  logic [DEPTH0-1:0] vld0_q;
  logic [DEPTHN-1:0] vldn_q;

  logic [BIN_W-1:0]  raddr0;
  logic [AN_W-1:0]   raddrn;
  logic [CNT_W-1:0]  rdata0, rdatan;
  logic [CNT_W-1:0]  data0, datan;
  logic [CNT_W-1:0]  wdata0, wdatan;
  logic              we0, wen;

  logic              inc0_q, incn_q, rd_en_q, rd_hi_q;
  logic [BIN_W-1:0]  addr0_q;
  logic [AN_W-1:0]   addrn_q;
  logic              hit0_q, hitn_q;

  logic              fwd0_q, fwdn_q;
  logic [BIN_W-1:0]  fwd0_addr_q;
  logic [AN_W-1:0]   fwdn_addr_q;
  logic [CNT_W-1:0]  fwd0_data_q, fwdn_data_q;

  assign raddr0 = req_i.bin0;
  assign raddrn = {req_i.lvln, req_i.binn};

  xpoc_ram #(
    .DEPTH (DEPTH0),
    .WIDTH (CNT_W)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (addr0_q),
    .wdata_i (wdata0),
    .re_i    (accept_i),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  xpoc_ram #(
    .DEPTH (DEPTHN),
    .WIDTH (CNT_W)
  ) u_ramn (
    .clk_i   (clk_i),
    .we_i    (wen),
    .waddr_i (addrn_q),
    .wdata_i (wdatan),
    .re_i    (accept_i),
    .raddr_i (raddrn),
    .rdata_o (rdatan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc0_q  <= 1'b0;
      incn_q  <= 1'b0;
      rd_en_q <= 1'b0;
      rd_hi_q <= 1'b0;
      hit0_q  <= 1'b0;
      hitn_q  <= 1'b0;
    end else if (accept_i) begin
      inc0_q  <= req_i.inc0;
      incn_q  <= req_i.incn;
      rd_en_q <= req_i.rd_en;
      rd_hi_q <= req_i.rd_hi;
      hit0_q  <= vld0_q[raddr0];
      hitn_q  <= vldn_q[raddrn];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      addr0_q <= raddr0;
      addrn_q <= raddrn;
    end
  end

  always_comb begin
    if (fwd0_q && fwd0_addr_q == addr0_q) begin
      data0 = fwd0_data_q;
    end else begin
      data0 = hit0_q ? rdata0 : '0;
    end
    if (fwdn_q && fwdn_addr_q == addrn_q) begin
      datan = fwdn_data_q;
    end else begin
      datan = hitn_q ? rdatan : '0;
    end
    wdata0    = sat_inc32(data0);
    wdatan    = sat_inc32(datan);
    we0       = advance_i && inc0_q;
    wen       = advance_i && incn_q;
    rd_data_o = !rd_en_q ? '0 : (rd_hi_q ? datan : data0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= '0;
      vldn_q <= '0;
      fwd0_q <= 1'b0;
      fwdn_q <= 1'b0;
    end else begin
      if (we0) begin
        vld0_q[addr0_q] <= 1'b1;
        fwd0_q          <= 1'b1;
      end
      if (wen) begin
        vldn_q[addrn_q] <= 1'b1;
        fwdn_q          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      fwd0_addr_q <= addr0_q;
      fwd0_data_q <= wdata0;
    end
    if (wen) begin
      fwdn_addr_q <= addrn_q;
      fwdn_data_q <= wdatan;
    end
  end

endmodule

FILE: hdl/xml_path_occurrence_counter_core.sv
// Top level of the XML path occurrence counter.
// Depends on xpoc_pkg, xpoc_path and xpoc_hist.
//
// Takes one event word per cycle while not stalled and returns one result word
// per event via the stage-1 and output registers. Path state, depth and counters
// update at acceptance; the histogram is read at acceptance and its increment is
// written back when the event advances to the output register, with the last
// write to each histogram RAM forwarded to a following read of the same entry.
// Level 0 and the deeper levels sit in separate RAMs so that closing the first
// level updates both bins in one pass. The histogram reads as zero after reset
// through per-entry valid flags, with no clearing pass. An output register
// holds a finished word while the next event is taken; input stall rises only
// when both the output register and the histogram stage are full.
module xml_path_occurrence_counter_core
  import xpoc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  cfg_idx_e    cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic             accept;
  logic             advance;
  path_rsp_t        rsp;
  hist_req_t        req;
  logic [CNT_W-1:0] hist_data;

  logic             s1_valid_q;
  path_rsp_t        s1_rsp_q;
  logic             out_valid_q;
  out_t             out_q;

  assign cfg_ready_o = 1'b1;
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;

  xpoc_path u_path (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_i        (in_data_i),
    .rsp_o       (rsp),
    .req_o       (req)
  );

  xpoc_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req),
    .advance_i (advance),
    .rd_data_o (hist_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rsp_q <= rsp;
    end
    if (advance) begin
      out_q.occurrence_count <= s1_rsp_q.occ;
      out_q.histogram_count  <= hist_data;
      out_q.current_depth    <= s1_rsp_q.depth;
      out_q.depth_error      <= s1_rsp_q.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/xpoc_checker.sv
// Port-level checker for the XML path occurrence counter, with its bind.
// Depends on xpoc_pkg and xml_path_occurrence_counter_core.
module xpoc_checker
  import xpoc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_stall_needs_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output word free");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_out_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output word changed under stall");

  a_error_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.depth_error |->
      out_data_o.current_depth == '0 || out_data_o.current_depth == DEPTH_MAX)
    else $error("depth error away from depth limits");

  a_error_no_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.depth_error |->
      out_data_o.occurrence_count == '0 && out_data_o.histogram_count == '0)
    else $error("counts returned with depth error");

endmodule

bind xml_path_occurrence_counter_core xpoc_checker u_xpoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
